@@ rtl/core/bad_pkg.sv @@
// ---------------------------------------------------------------------------
// bad_pkg
// Shared codes and address decode for the bus address decoder.
// ---------------------------------------------------------------------------
package bad_pkg;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_IRQ   = 2'd2;

    typedef logic [2:0] t_target;

    localparam t_target TGT_LOCAL  = 3'd0;
    localparam t_target TGT_CART   = 3'd1;
    localparam t_target TGT_VRAM   = 3'd2;
    localparam t_target TGT_OAM    = 3'd3;
    localparam t_target TGT_JOYPAD = 3'd4;
    localparam t_target TGT_TIMER  = 3'd5;
    localparam t_target TGT_AUDIO  = 3'd6;
    localparam t_target TGT_VIDEO  = 3'd7;

    localparam logic [15:0] ADDR_SB   = 16'hFF01;
    localparam logic [15:0] ADDR_SC   = 16'hFF02;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_IE   = 16'hFFFF;
    localparam logic [15:0] HRAM_BASE = 16'hFF80;

    localparam logic [7:0] SC_READ_MASK = 8'h7E;
    localparam logic [7:0] IF_READ_MASK = 8'hE0;
    localparam logic [7:0] DMA_PAGE_MAX = 8'hF1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        t_target     target;
    } t_item;

    function automatic t_target pick_target(input logic [15:0] a);
        t_target t;
        t = TGT_LOCAL;
        if (a < 16'h8000) begin
            t = TGT_CART;
        end else if (a < 16'hA000) begin
            t = TGT_VRAM;
        end else if (a < 16'hC000) begin
            t = TGT_CART;
        end else if (a < 16'hFE00) begin
            t = TGT_LOCAL;
        end else if (a < 16'hFEA0) begin
            t = TGT_OAM;
        end else if (a == 16'hFF00) begin
            t = TGT_JOYPAD;
        end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
            t = TGT_TIMER;
        end else if (a >= 16'hFF10 && a <= 16'hFF3F) begin
            t = TGT_AUDIO;
        end else if (a >= 16'hFF40 && a <= 16'hFF4B && a != ADDR_DMA) begin
            t = TGT_VIDEO;
        end
        return t;
    endfunction

endpackage

@@ rtl/core/bus_address_decoder_unit.sv @@
// ---------------------------------------------------------------------------
// bus_address_decoder_unit
// Memory map decoder: routes bus transfers to external units by target code,
// serves work RAM, high RAM and local I/O registers from on-chip storage.
// ---------------------------------------------------------------------------
//  channel   | ports                                     | handshake
//  ----------+-------------------------------------------+--------------------
//  request   | i_kind i_addr i_wdata i_irq_bit           | start high, busy low
//  result    | o_target o_rdata o_ext_write o_ext_addr   | o_strobe, 1 cycle
//            | o_ext_wdata o_dma_start o_dma_source      |
//
//  one transfer per cycle while busy is low; the accepting edge registers
//  the request and reads the work RAM / high RAM arrays (memory read stage),
//  then the output register puts the result on the ports with o_strobe. ram
//  writes land at the accept edge, so a following read of the same entry sees
//  the new byte without stalling.
//  busy is high during reset and in the cycle after it. the receiver cannot stall.
module bus_address_decoder_unit
    import bad_pkg::*;
#(
    parameter int WORK_RAM_DEPTH = 8192,
    parameter int HIGH_RAM_DEPTH = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [2:0]  i_irq_bit,
    output logic        o_strobe,
    output logic [2:0]  o_target,
    output logic [7:0]  o_rdata,
    output logic        o_ext_write,
    output logic [15:0] o_ext_addr,
    output logic [7:0]  o_ext_wdata,
    output logic        o_dma_start,
    output logic [15:0] o_dma_source
);

    localparam int WR_AW = $clog2(WORK_RAM_DEPTH);
    localparam int HR_AW = $clog2(HIGH_RAM_DEPTH);

    logic [7:0] r_wram [0:WORK_RAM_DEPTH-1];
    logic [7:0] r_hram [0:HIGH_RAM_DEPTH-1];
    logic [7:0] r_wram_q;
    logic [7:0] r_hram_q;

    logic       r_busy;
    logic       r_s1_valid;
    t_item      r_s1;

    logic [4:0] r_irq_flags;
    logic [7:0] r_irq_enable;
    logic [7:0] r_serial_data;
    logic [1:0] r_serial_ctl;
    logic [7:0] r_dma_page;

    logic             accept;
    t_target          in_target;
    logic             wram_hit;
    logic             hram_hit;
    logic             local_wr;
    logic [WR_AW-1:0] wram_idx;
    logic [HR_AW-1:0] hram_idx;
    logic [15:0]      hram_off;
    logic [7:0]       dma_page_clamped;

    logic [7:0]  n_rdata;
    logic        n_ext_write;
    logic [15:0] n_ext_addr;
    logic [7:0]  n_ext_wdata;
    logic        n_dma_start;
    logic [15:0] n_dma_source;
    logic [7:0]  s1_clamped;

    assign busy      = r_busy;
    assign accept    = start && !r_busy;
    assign in_target = pick_target(i_addr);
    assign wram_hit  = (i_addr >= 16'hC000) && (i_addr < 16'hFE00);
    assign hram_hit  = (i_addr >= HRAM_BASE) && (i_addr <= 16'hFFFE);
    assign local_wr  = accept && (i_kind == KIND_WRITE) && (in_target == TGT_LOCAL);
    assign wram_idx  = i_addr[WR_AW-1:0];
    assign hram_off  = i_addr - HRAM_BASE;
    assign hram_idx  = hram_off[HR_AW-1:0];

    assign dma_page_clamped = (i_wdata > DMA_PAGE_MAX) ? DMA_PAGE_MAX : i_wdata;

    // work RAM: echo region folds onto the same entries by the low address bits
    always_ff @(posedge i_clk) begin
        if (local_wr && wram_hit) begin
            r_wram[wram_idx] <= i_wdata;
        end
        if (accept && wram_hit) begin
            r_wram_q <= r_wram[wram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (local_wr && hram_hit) begin
            r_hram[hram_idx] <= i_wdata;
        end
        if (accept && hram_hit) begin
            r_hram_q <= r_hram[hram_idx];
        end
    end

    // local register file, updated at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_flags   <= '0;
            r_irq_enable  <= '0;
            r_serial_data <= '0;
            r_serial_ctl  <= '0;
            r_dma_page    <= '0;
        end else if (accept) begin
            if (i_kind == KIND_IRQ) begin
                // bits beyond the 5-bit register shift out and change nothing
                r_irq_flags <= r_irq_flags | (5'b00001 << i_irq_bit);
            end else if (local_wr) begin
                case (i_addr)
                    ADDR_SB:  r_serial_data <= i_wdata;
                    ADDR_SC:  r_serial_ctl  <= {i_wdata[7], i_wdata[0]};
                    ADDR_IF:  r_irq_flags   <= i_wdata[4:0];
                    ADDR_DMA: r_dma_page    <= dma_page_clamped;
                    ADDR_IE:  r_irq_enable  <= i_wdata;
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.kind   <= i_kind;
            r_s1.addr   <= i_addr;
            r_s1.wdata  <= i_wdata;
            r_s1.target <= in_target;
        end
    end

    assign s1_clamped = (r_s1.wdata > DMA_PAGE_MAX) ? DMA_PAGE_MAX : r_s1.wdata;

    always_comb begin
        n_rdata      = '0;
        n_ext_write  = 1'b0;
        n_ext_addr   = '0;
        n_ext_wdata  = '0;
        n_dma_start  = 1'b0;
        n_dma_source = '0;
        if (r_s1.kind == KIND_READ || r_s1.kind == KIND_WRITE) begin
            if (r_s1.target != TGT_LOCAL) begin
                n_ext_addr = r_s1.addr;
                if (r_s1.kind == KIND_WRITE) begin
                    n_ext_write = 1'b1;
                    n_ext_wdata = r_s1.wdata;
                end
            end else if (r_s1.kind == KIND_READ) begin
                case (r_s1.addr) inside
                    [16'hC000:16'hFDFF]: n_rdata = r_wram_q;
                    [16'hFE00:16'hFEFF]: n_rdata = 8'h00;
                    ADDR_SB:             n_rdata = r_serial_data;
                    ADDR_SC:             n_rdata = {r_serial_ctl[1], 6'b0, r_serial_ctl[0]}
                                                   | SC_READ_MASK;
                    ADDR_IF:             n_rdata = {3'b000, r_irq_flags} | IF_READ_MASK;
                    ADDR_DMA:            n_rdata = r_dma_page;
                    [16'hFF80:16'hFFFE]: n_rdata = r_hram_q;
                    ADDR_IE:             n_rdata = r_irq_enable;
                    default:             n_rdata = 8'hFF;
                endcase
            end else if (r_s1.addr == ADDR_DMA) begin
                n_dma_start  = 1'b1;
                n_dma_source = {s1_clamped, 8'h00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            o_target     <= ((r_s1.kind == KIND_READ) || (r_s1.kind == KIND_WRITE))
                            ? r_s1.target : TGT_LOCAL;
            o_rdata      <= n_rdata;
            o_ext_write  <= n_ext_write;
            o_ext_addr   <= n_ext_addr;
            o_ext_wdata  <= n_ext_wdata;
            o_dma_start  <= n_dma_start;
            o_dma_source <= n_dma_source;
        end
    end

endmodule
